// ===== sv/hcfr_pkg.sv =====
// Shared constants and types of the header checksum frame receiver.
package hcfr_pkg;

    localparam int unsigned WinDepth = 7;
    localparam int unsigned CntW     = 3;

    typedef logic [7:0]      byte_t;
    typedef logic [CntW-1:0] cnt_t;

    localparam byte_t HDR_FIRST  = 8'h55;
    localparam byte_t HDR_SECOND = 8'h5A;

    localparam logic [1:0] REG_EXPECTED_CMD = 2'd0;
    localparam logic [1:0] REG_FRAME_LEN    = 2'd1;

    localparam byte_t CMD_RESET       = 8'h00;
    localparam cnt_t  FRAME_LEN_SHORT = 3'd6;
    localparam cnt_t  FRAME_LEN_LONG  = 3'd7;
    localparam cnt_t  FRAME_LEN_RESET = FRAME_LEN_SHORT;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ALIGN = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DROP  = 4'b1000
    } state_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

// ===== sv/hcfr_ifs.sv =====
// Channel interfaces of the frame receiver: received bytes, responses and register writes.
interface hcfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcfr_resp_if;
    logic       valid;
    logic       ready;
    logic [7:0] resp_cmd;
    logic [7:0] resp_byte3;
    logic [7:0] resp_byte4;
    logic [7:0] resp_byte5;

    modport source (output valid, output resp_cmd, output resp_byte3,
                    output resp_byte4, output resp_byte5, input ready);
    modport sink   (input valid, input resp_cmd, input resp_byte3,
                    input resp_byte4, input resp_byte5, output ready);
endinterface

interface hcfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/hcfr_cell.sv =====
// One byte cell of the receive window, loading a new byte or its right neighbour.
module hcfr_cell
    import hcfr_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  byte_t     rx_byte,
    input  byte_t     next_byte,
    output byte_t     q
);

    byte_t byte_reg;
    byte_t byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.load)
        begin
            byte_next = rx_byte;
        end
        else if (ctl.shift)
        begin
            byte_next = next_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule

// ===== sv/hcfr_ctrl.sv =====
// Sequencer of the frame receiver: fill count, header alignment, frame check and response register.
module hcfr_ctrl
    import hcfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    output logic      rx_ready,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  byte_t     cfg_data,
    input  byte_t     win [WinDepth],
    output cell_ctl_t cell_ctl [WinDepth],
    output logic      resp_valid,
    input  logic      resp_ready,
    output byte_t     resp_cmd,
    output byte_t     resp_byte3,
    output byte_t     resp_byte4,
    output byte_t     resp_byte5
);

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    cnt_t   drop_reg, drop_next;
    byte_t  cmd_reg;
    cnt_t   flen_reg;
    logic   out_valid_reg, out_valid_next;
    byte_t  out_cmd_reg, out_b3_reg, out_b4_reg, out_b5_reg;

    cnt_t   len;
    cnt_t   cnt_after;
    logic   hdr_at_front;
    byte_t  sum_short;
    byte_t  sum_long;
    logic   chk_ok;
    logic   out_free;
    logic   shift;
    logic   load;
    logic   out_load;

    assign len       = (flen_reg == FRAME_LEN_LONG) ? FRAME_LEN_LONG : FRAME_LEN_SHORT;
    assign cnt_after = (count_reg == CntW'(WinDepth)) ? count_reg : count_reg + cnt_t'(1);

    assign hdr_at_front = (count_reg >= cnt_t'(2)) && (win[0] == HDR_FIRST)
                          && (win[1] == HDR_SECOND);

    // The checksum covers the command up to the byte before the last one.
    assign sum_short = win[2] + win[3] + win[4];
    assign sum_long  = sum_short + win[5];
    assign chk_ok    = (win[2] == cmd_reg)
                       && ((len == FRAME_LEN_LONG) ? (sum_long == win[6])
                                                   : (sum_short == win[5]));

    assign out_free  = !out_valid_reg || resp_ready;
    assign rx_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        shift      = 1'b0;
        load       = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid)
                begin
                    // A full window takes no further byte; the transfer still completes.
                    load       = (count_reg != CntW'(WinDepth));
                    count_next = cnt_after;
                    if (cnt_after >= len)
                    begin
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                if (hdr_at_front)
                begin
                    state_next = ST_CHECK;
                end
                else if (count_reg <= cnt_t'(1))
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    shift      = 1'b1;
                    count_next = count_reg - cnt_t'(1);
                end
            end
            ST_CHECK:
            begin
                if (count_reg < len)
                begin
                    state_next = ST_IDLE;
                end
                else if (!chk_ok)
                begin
                    shift      = 1'b1;
                    count_next = count_reg - cnt_t'(1);
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    if (count_reg == len)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        drop_next  = len;
                        state_next = ST_DROP;
                    end
                end
            end
            ST_DROP:
            begin
                shift      = 1'b1;
                count_next = count_reg - cnt_t'(1);
                drop_next  = drop_reg - cnt_t'(1);
                if (drop_reg == cnt_t'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < WinDepth; i++)
        begin
            cell_ctl[i].shift = shift;
            cell_ctl[i].load  = load && (count_reg == CntW'(i));
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (resp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_RESET;
            flen_reg      <= FRAME_LEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_EXPECTED_CMD: cmd_reg  <= cfg_data;
                    REG_FRAME_LEN:    flen_reg <= cfg_data[CntW-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cmd_reg <= win[2];
            out_b3_reg  <= win[3];
            out_b4_reg  <= win[4];
            out_b5_reg  <= win[5];
        end
    end

    assign resp_valid = out_valid_reg;
    assign resp_cmd   = out_cmd_reg;
    assign resp_byte3 = out_b3_reg;
    assign resp_byte4 = out_b4_reg;
    assign resp_byte5 = out_b5_reg;

endmodule

// ===== sv/header_checksum_frame_receiver.sv =====
// Header checksum frame receiver: a seven-cell byte window with a shifting aligner and frame check.
// Flow: a byte that leaves the window short of a frame needs only its transfer; otherwise the
// transfer is followed by one shift per byte dropped while aligning (up to six), a step that finds
// the header or clears the window, the check (held while a response waits) and, when a long window
// sheds a short frame, one shift per byte shed; no byte is taken until the sequencer is idle again.
// The response is registered by the check; reset clears count, sequencer and flag.
module header_checksum_frame_receiver
    import hcfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hcfr_rx_if.sink     rx,
    hcfr_resp_if.source resp,
    hcfr_cfg_if.sink    cfg
);

    byte_t     win [WinDepth];
    cell_ctl_t cell_ctl [WinDepth];

    hcfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx.valid),
        .rx_ready   (rx.ready),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .win        (win),
        .cell_ctl   (cell_ctl),
        .resp_valid (resp.valid),
        .resp_ready (resp.ready),
        .resp_cmd   (resp.resp_cmd),
        .resp_byte3 (resp.resp_byte3),
        .resp_byte4 (resp.resp_byte4),
        .resp_byte5 (resp.resp_byte5)
    );

    // Each cell takes its right neighbour's byte on a shift; the last one has no neighbour.
    for (genvar i = 0; i < WinDepth; i++)
    begin : g_cell
        if (i == WinDepth - 1)
        begin : g_last
            hcfr_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[i]),
                .rx_byte   (rx.rx_byte),
                .next_byte (8'h00),
                .q         (win[i])
            );
        end
        else
        begin : g_mid
            hcfr_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[i]),
                .rx_byte   (rx.rx_byte),
                .next_byte (win[i+1]),
                .q         (win[i])
            );
        end
    end

endmodule

// ===== sv/hcfr_checker.sv =====
// Port-level checker of the frame receiver and its bind to the top level.
module hcfr_checker
    import hcfr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       resp_valid,
    input logic       resp_ready,
    input byte_t      resp_cmd,
    input byte_t      resp_byte3,
    input byte_t      resp_byte4,
    input byte_t      resp_byte5,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [1:0] cfg_index,
    input byte_t      cfg_data
);

    byte_t cmd_reg;
    cnt_t  flen_reg;
    byte_t resp_sum;

    // Shadow copies of the registers, as seen from the write transfers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg  <= CMD_RESET;
            flen_reg <= FRAME_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EXPECTED_CMD: cmd_reg  <= cfg_data;
                REG_FRAME_LEN:    flen_reg <= cfg_data[CntW-1:0];
                default:          ;
            endcase
        end
    end

    assign resp_sum = resp_cmd + resp_byte3 + resp_byte4;

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(resp_cmd)
        && $stable(resp_byte3) && $stable(resp_byte4) && $stable(resp_byte5))
        else $error("response changed while stalled");

    a_resp_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> resp_cmd == cmd_reg)
        else $error("response carries an unexpected command");

    // In a six-byte frame the last byte shown is the checksum itself.
    a_resp_sum: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && (flen_reg != FRAME_LEN_LONG) |-> resp_sum == resp_byte5)
        else $error("short frame response fails its checksum");

    a_resp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid) |-> $past(!rx_ready))
        else $error("response appeared without a frame check cycle");

endmodule

bind header_checksum_frame_receiver hcfr_checker u_hcfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_ready   (rx.ready),
    .resp_valid (resp.valid),
    .resp_ready (resp.ready),
    .resp_cmd   (resp.resp_cmd),
    .resp_byte3 (resp.resp_byte3),
    .resp_byte4 (resp.resp_byte4),
    .resp_byte5 (resp.resp_byte5),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data)
);
